@@ hdl/rpe_pkg.sv @@
package rpe_pkg;

    // Defaults for the top-level parameters
    localparam int HEAD_MAX_DEF   = 128;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF = 16;

    // Configuration register fields
    localparam int CFG_W   = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] HEAD_SIZE_RST   = 8'd128;
    localparam logic [CFG_W-1:0] ROTARY_SPAN_RST = 8'd0;
    localparam logic             NEOX_MODE_RST   = 1'b1;

    // Input item kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_LOAD_COEF = 2'd0,
        OP_LOAD_HEAD = 2'd1,
        OP_READ      = 2'd2
    } rpe_op_t;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_HEAD_SIZE   = 2'd0,
        REG_ROTARY_SPAN = 2'd1,
        REG_NEOX_MODE   = 2'd2
    } rpe_reg_t;

    // Per-item control that travels down the datapath
    typedef struct packed {
        logic valid;   // a read item occupies this stage
        logic pass;    // element passes through unrotated
        logic zero;    // position lies beyond the stores, return zero
        logic is_x;    // first element of its pair
    } rpe_ctl_t;

endpackage

@@ hdl/rpe_store.sv @@
module rpe_store #(
    parameter int DEPTH  = rpe_pkg::HEAD_MAX_DEF,
    parameter int WIDTH  = rpe_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [WIDTH-1:0]  rdata0,
    output logic [WIDTH-1:0]  rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Two registered read ports; hold the data while the pipe is stalled
    always_ff @(posedge aclk) begin
        if (re) begin
            rd0_reg <= mem_reg[raddr0];
            rd1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

@@ hdl/rpe_rotate.sv @@
module rpe_rotate #(
    parameter int DATA_WIDTH = rpe_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = rpe_pkg::COEF_WIDTH_DEF,
    parameter int IDX_W      = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  rpe_pkg::rpe_ctl_t     ctl_i,
    input  logic [IDX_W-1:0]      idx_i,
    input  logic [DATA_WIDTH-1:0] x_i,
    input  logic [DATA_WIDTH-1:0] y_i,
    input  logic [COEF_WIDTH-1:0] c_i,
    input  logic [COEF_WIDTH-1:0] s_i,
    output logic                  out_valid,
    output logic [IDX_W-1:0]      out_index,
    output logic [DATA_WIDTH-1:0] out_value,
    output logic                  out_sat
);

    localparam int PW = DATA_WIDTH + COEF_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] RND =
        {{(SW-COEF_WIDTH+1){1'b0}}, 1'b1, {(COEF_WIDTH-2){1'b0}}};
    localparam logic signed [SW-1:0] LIM_HI =
        {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] LIM_LO =
        {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    rpe_pkg::rpe_ctl_t      ctl_b_reg;
    logic [IDX_W-1:0]       idx_b_reg;
    logic signed [PW-1:0]   p0_reg;
    logic signed [PW-1:0]   p1_reg;
    logic [DATA_WIDTH-1:0]  pass_val_reg;

    logic signed [DATA_WIDTH-1:0] mul_a;
    logic signed [DATA_WIDTH-1:0] mul_b;
    logic signed [PW-1:0]         p0_next;
    logic signed [PW-1:0]         p1_next;

    logic                  valid_c_reg;
    logic [IDX_W-1:0]      idx_c_reg;
    logic [DATA_WIDTH-1:0] value_c_reg;
    logic                  sat_c_reg;

    logic signed [SW-1:0]  acc;
    logic signed [SW-1:0]  shifted;
    logic [DATA_WIDTH-1:0] value_next;
    logic                  sat_next;

    // Stage B: x*cos and y*sin for the first element, y*cos and x*sin for the second
    always_comb begin
        mul_a   = ctl_i.is_x ? signed'(x_i) : signed'(y_i);
        mul_b   = ctl_i.is_x ? signed'(y_i) : signed'(x_i);
        p0_next = mul_a * signed'(c_i);
        p1_next = mul_b * signed'(s_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_b_reg <= '0;
        end else if (adv) begin
            ctl_b_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_b_reg    <= idx_i;
            p0_reg       <= p0_next;
            p1_reg       <= p1_next;
            pass_val_reg <= x_i;
        end
    end

    // Stage C: combine, round half up, saturate; zero and pass items override the result
    always_comb begin
        if (ctl_b_reg.is_x) begin
            acc = SW'(p0_reg) - SW'(p1_reg);
        end else begin
            acc = SW'(p0_reg) + SW'(p1_reg);
        end
        shifted = (acc + RND) >>> (COEF_WIDTH - 1);
        sat_next = 1'b0;
        if (shifted > LIM_HI) begin
            value_next = LIM_HI[DATA_WIDTH-1:0];
            sat_next   = 1'b1;
        end else if (shifted < LIM_LO) begin
            value_next = LIM_LO[DATA_WIDTH-1:0];
            sat_next   = 1'b1;
        end else begin
            value_next = shifted[DATA_WIDTH-1:0];
        end
        if (ctl_b_reg.zero) begin
            value_next = '0;
            sat_next   = 1'b0;
        end else if (ctl_b_reg.pass) begin
            value_next = pass_val_reg;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_c_reg <= 1'b0;
        end else if (adv) begin
            valid_c_reg <= ctl_b_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_c_reg   <= idx_b_reg;
            value_c_reg <= value_next;
            sat_c_reg   <= sat_next;
        end
    end

    assign out_valid = valid_c_reg;
    assign out_index = idx_c_reg;
    assign out_value = value_c_reg;
    assign out_sat   = sat_c_reg;

endmodule

@@ hdl/rotary_position_embedding_unit.sv @@
// Channel  | Ports            | tdata (low bit up)  | tuser      | Moves
// ---------+------------------+---------------------+------------+---------------------------
// input    | s_tvalid/tready  | index, value        | op         | load coef, load head, read
// result   | m_tvalid/tready  | out_index, out_value| saturated  | one per read transfer
// config   | APB psel/penable | reg at 4*i          | -          | head_size, rotary_span, neox
//
// A read transfer reaches m_tdata through the registered read of both dual-port stores,
// then the register after the two multipliers, then the round/saturate output
// register. One transfer per cycle while m_tready stays high.
// A load writes its store at the edge it is taken, so any later read sees it.
// Reset clears the pipe valid bits and the configuration registers only; stores start undefined.
// A held result freezes the whole pipe and drops s_tready in the same cycle.
module rotary_position_embedding_unit #(
    parameter int HEAD_MAX   = rpe_pkg::HEAD_MAX_DEF,
    parameter int DATA_WIDTH = rpe_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = rpe_pkg::COEF_WIDTH_DEF,
    localparam int IDX_W     = $clog2(HEAD_MAX),
    localparam int VAL_W     = (DATA_WIDTH > COEF_WIDTH) ? DATA_WIDTH : COEF_WIDTH,
    localparam int S_TDATA_W = ((IDX_W + VAL_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((IDX_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_TDATA_W-1:0]        s_tdata,   // index, value, zero fill
    input  logic [1:0]                  s_tuser,   // op
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // out_index, out_value, zero fill
    output logic                        m_tuser,   // saturated
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpe_pkg::PADDR_W-1:0] paddr,
    input  logic [rpe_pkg::PDATA_W-1:0] pwdata,
    output logic [rpe_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int LEN_W =
        (($clog2(HEAD_MAX + 1) > rpe_pkg::CFG_W) ? $clog2(HEAD_MAX + 1) : rpe_pkg::CFG_W) + 1;
    localparam logic [LEN_W-1:0] HEAD_MAX_L = LEN_W'(HEAD_MAX);
    localparam logic [LEN_W-1:0] TWO_L      = LEN_W'(2);

    // ---------------- configuration registers ----------------
    logic [rpe_pkg::CFG_W-1:0] head_size_reg;
    logic [rpe_pkg::CFG_W-1:0] rotary_span_reg;
    logic                      neox_mode_reg;
    logic                      cfg_wr;
    rpe_pkg::rpe_reg_t         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = rpe_pkg::rpe_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_size_reg   <= rpe_pkg::HEAD_SIZE_RST;
            rotary_span_reg <= rpe_pkg::ROTARY_SPAN_RST;
            neox_mode_reg   <= rpe_pkg::NEOX_MODE_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                rpe_pkg::REG_HEAD_SIZE:   head_size_reg   <= pwdata[rpe_pkg::CFG_W-1:0];
                rpe_pkg::REG_ROTARY_SPAN: rotary_span_reg <= pwdata[rpe_pkg::CFG_W-1:0];
                rpe_pkg::REG_NEOX_MODE:   neox_mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            rpe_pkg::REG_HEAD_SIZE:   prdata = rpe_pkg::PDATA_W'(head_size_reg);
            rpe_pkg::REG_ROTARY_SPAN: prdata = rpe_pkg::PDATA_W'(rotary_span_reg);
            rpe_pkg::REG_NEOX_MODE:   prdata = rpe_pkg::PDATA_W'(neox_mode_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- input decode and address generation ----------------
    logic                  adv;
    logic                  s_xfer;
    logic [IDX_W-1:0]      in_index;
    logic [VAL_W-1:0]      in_value;
    logic                  in_fits;

    logic [LEN_W-1:0]      h_len;
    logic [LEN_W-1:0]      s_len;
    logic [LEN_W-1:0]      half_len;
    logic [LEN_W-1:0]      t_len;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      xpos_len;
    logic [LEN_W-1:0]      ypos_len;
    logic [LEN_W-1:0]      spos_len;
    logic                  is_x0;
    logic                  pass0;

    logic [IDX_W-1:0]      buf_raddr0;
    logic [IDX_W-1:0]      buf_raddr1;
    logic                  buf_we;
    logic                  coef_we;
    rpe_pkg::rpe_ctl_t     ctl_a_next;

    // Advance the pipe whenever the output register is free or being drained
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_index = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W +: VAL_W];
    assign t_len    = LEN_W'(in_index);
    assign in_fits  = t_len < HEAD_MAX_L;

    always_comb begin
        // Clamp head size, then resolve the rotary span
        h_len = LEN_W'(head_size_reg);
        if (h_len < TWO_L) begin
            h_len = TWO_L;
        end else if (h_len > HEAD_MAX_L) begin
            h_len = HEAD_MAX_L;
        end
        s_len = LEN_W'(rotary_span_reg);
        if (s_len == '0 || s_len > h_len) begin
            s_len = h_len;
        end
        half_len = s_len >> 1;
        pass0    = (t_len >= h_len) || (t_len >= (half_len << 1));

        if (neox_mode_reg) begin
            is_x0    = t_len < half_len;
            r_len    = is_x0 ? t_len : t_len - half_len;
            xpos_len = r_len;
            ypos_len = r_len + half_len;
        end else begin
            is_x0    = !t_len[0];
            r_len    = t_len >> 1;
            xpos_len = r_len << 1;
            ypos_len = xpos_len + LEN_W'(1);
        end
        spos_len = r_len + half_len;

        // Port 0 carries either the x element or the passed-through element
        if (pass0) begin
            buf_raddr0 = in_fits ? in_index : '0;
        end else begin
            buf_raddr0 = xpos_len[IDX_W-1:0];
        end
        buf_raddr1 = ypos_len[IDX_W-1:0];

        ctl_a_next.valid = s_xfer && (s_tuser == rpe_pkg::OP_READ);
        ctl_a_next.pass  = pass0;
        ctl_a_next.zero  = pass0 && !in_fits;
        ctl_a_next.is_x  = is_x0;
    end

    always_comb begin
        buf_we  = 1'b0;
        coef_we = 1'b0;
        case (rpe_pkg::rpe_op_t'(s_tuser))
            rpe_pkg::OP_LOAD_COEF: coef_we = s_xfer && in_fits;
            rpe_pkg::OP_LOAD_HEAD: buf_we  = s_xfer && in_fits;
            default: ;
        endcase
    end

    // ---------------- stores (stage A: registered read data) ----------------
    logic [DATA_WIDTH-1:0] x_rd;
    logic [DATA_WIDTH-1:0] y_rd;
    logic [COEF_WIDTH-1:0] c_rd;
    logic [COEF_WIDTH-1:0] s_rd;

    rpe_store #(
        .DEPTH  (HEAD_MAX),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (IDX_W)
    ) u_head_buffer (
        .aclk   (aclk),
        .we     (buf_we),
        .waddr  (in_index),
        .wdata  (in_value[DATA_WIDTH-1:0]),
        .re     (adv),
        .raddr0 (buf_raddr0),
        .raddr1 (buf_raddr1),
        .rdata0 (x_rd),
        .rdata1 (y_rd)
    );

    rpe_store #(
        .DEPTH  (HEAD_MAX),
        .WIDTH  (COEF_WIDTH),
        .ADDR_W (IDX_W)
    ) u_coef_store (
        .aclk   (aclk),
        .we     (coef_we),
        .waddr  (in_index),
        .wdata  (in_value[COEF_WIDTH-1:0]),
        .re     (adv),
        .raddr0 (r_len[IDX_W-1:0]),
        .raddr1 (spos_len[IDX_W-1:0]),
        .rdata0 (c_rd),
        .rdata1 (s_rd)
    );

    // Control and index ride alongside the read data
    rpe_pkg::rpe_ctl_t ctl_a_reg;
    logic [IDX_W-1:0]  idx_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
        end else if (adv) begin
            ctl_a_reg <= ctl_a_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_a_reg <= in_index;
        end
    end

    // ---------------- rotation datapath (stages B and C) ----------------
    logic [IDX_W-1:0]      res_index;
    logic [DATA_WIDTH-1:0] res_value;
    logic                  res_sat;

    rpe_rotate #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH),
        .IDX_W      (IDX_W)
    ) u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .ctl_i     (ctl_a_reg),
        .idx_i     (idx_a_reg),
        .x_i       (x_rd),
        .y_i       (y_rd),
        .c_i       (c_rd),
        .s_i       (s_rd),
        .out_valid (m_tvalid),
        .out_index (res_index),
        .out_value (res_value),
        .out_sat   (res_sat)
    );

    assign m_tdata = M_TDATA_W'({res_value, res_index});
    assign m_tuser = res_sat;

`ifndef NO_ASSERTIONS
    // Loads and unused codes never enter the result pipe
    a_no_result_for_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser != rpe_pkg::OP_READ) |=> !ctl_a_reg.valid)
        else $error("non-read transfer entered the result pipe");

    // A stall must hold stage A control and the registered store data
    a_stall_holds_stage_a: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(ctl_a_reg) && $stable(x_rd) && $stable(c_rd)))
        else $error("stage A changed during a stall");

    // The partner of a rotated element always lies inside the clamped head
    a_pair_in_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tuser == rpe_pkg::OP_READ && !pass0) |->
            (ypos_len < h_len && spos_len < h_len))
        else $error("rotation pair address outside the head");
`endif

endmodule
